### design/gpb_pkg.sv
// ---------------------------------------------------------------------------
// gpb_pkg
// Shared types and constants for the glyph pixel blit and format pack block.
// ---------------------------------------------------------------------------
`default_nettype none

package gpb_pkg;

  // Fixed field widths
  localparam int DIM_W   = 12;
  localparam int POS_W   = 13;
  localparam int COV_W   = 8;
  localparam int COLOR_W = 32;
  localparam int ADDR_W  = 24;
  localparam int FMT_W   = 4;
  localparam int CFG_IDX_W = 2;

  // Default clip limit for width and height
  localparam int DEFAULT_MAX_DIM = 2048;

  // Register reset values
  localparam logic [DIM_W-1:0]   RESET_WIDTH  = 12'd2048;
  localparam logic [DIM_W-1:0]   RESET_HEIGHT = 12'd2048;
  localparam logic [COLOR_W-1:0] RESET_COLOR  = 32'h0000_0000;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_PIXEL_FORMAT = 2'd2,
    CFG_TEXT_COLOR   = 2'd3
  } cfg_index_t;

  // Pixel format codes
  typedef enum logic [FMT_W-1:0] {
    FMT_RGB444   = 4'd0,
    FMT_RGB555   = 4'd1,
    FMT_RGB565   = 4'd2,
    FMT_RGB888   = 4'd3,
    FMT_BGR444   = 4'd4,
    FMT_BGR555   = 4'd5,
    FMT_BGR565   = 4'd6,
    FMT_BGR888   = 4'd7,
    FMT_ARGB1555 = 4'd8,
    FMT_ARGB4444 = 4'd9,
    FMT_ARGB8565 = 4'd10,
    FMT_ARGB8888 = 4'd11,
    FMT_ABGR1555 = 4'd12,
    FMT_ABGR4444 = 4'd13,
    FMT_ABGR8565 = 4'd14,
    FMT_ABGR8888 = 4'd15
  } pixel_format_t;

  // Channel depth group inside a format family (low two bits of the code).
  // Names give the no-alpha and the alpha variant.
  typedef enum logic [1:0] {
    DEPTH_444_1555 = 2'd0,
    DEPTH_555_4444 = 2'd1,
    DEPTH_565_8565 = 2'd2,
    DEPTH_888_8888 = 2'd3
  } depth_t;

  // Live configuration handed from the register file to the datapath
  typedef struct packed {
    logic [DIM_W-1:0]   frame_width;
    logic [DIM_W-1:0]   frame_height;
    pixel_format_t      pixel_format;
    logic [COLOR_W-1:0] text_color;
  } cfg_t;

endpackage

`default_nettype wire

### design/glyph_pixel_blit_format_pack.sv
// ---------------------------------------------------------------------------
// glyph_pixel_blit_format_pack
// Clips glyph pixels to the frame and emits packed frame buffer writes.
// ---------------------------------------------------------------------------
// One glyph pixel per clock goes in unless the output is held, and at most
// one write comes out: an input register, then the clip test, the color pack
// and the 12x12 address multiply, then a result register. A pixel with zero
// coverage or outside the frame makes no write. Width and height above
// MAX_DIM are saturated. Configuration is a plain write port (index 0 width,
// 1 height, 2 pixel format, 3 ARGB8888 text color) and should only be
// written while no pixel is in flight.
`default_nettype none

module glyph_pixel_blit_format_pack
  import gpb_pkg::*;
#(
  parameter int MAX_DIM = DEFAULT_MAX_DIM
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_write,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [COLOR_W-1:0]      cfg_data,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic signed [POS_W-1:0] dest_x,
  input  wire logic signed [POS_W-1:0] dest_y,
  input  wire logic [COV_W-1:0]        coverage,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [ADDR_W-1:0]            byte_address,
  output logic [COLOR_W-1:0]           pixel_data,
  output logic                         write_wide
);

  cfg_t cfg;

  gpb_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  gpb_blit_stage #(
    .MAX_DIM (MAX_DIM)
  ) u_blit (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .dest_x       (dest_x),
    .dest_y       (dest_y),
    .coverage     (coverage),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .byte_address (byte_address),
    .pixel_data   (pixel_data),
    .write_wide   (write_wide)
  );

endmodule

`default_nettype wire

### design/gpb_cfg_regs.sv
// ---------------------------------------------------------------------------
// gpb_cfg_regs
// Configuration register file: frame size, pixel format and text color.
// ---------------------------------------------------------------------------
`default_nettype none

module gpb_cfg_regs
  import gpb_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [COLOR_W-1:0]   cfg_data,
  output cfg_t                      cfg
);

  cfg_t regs;

  // Decode the write index and update one register
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.frame_width  <= RESET_WIDTH;
      regs.frame_height <= RESET_HEIGHT;
      regs.pixel_format <= FMT_ARGB1555;
      regs.text_color   <= RESET_COLOR;
    end else if (cfg_write) begin
      case (cfg_index_t'(cfg_index))
        CFG_FRAME_WIDTH:  regs.frame_width  <= cfg_data[DIM_W-1:0];
        CFG_FRAME_HEIGHT: regs.frame_height <= cfg_data[DIM_W-1:0];
        CFG_PIXEL_FORMAT: regs.pixel_format <= pixel_format_t'(cfg_data[FMT_W-1:0]);
        CFG_TEXT_COLOR:   regs.text_color   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign cfg = regs;

endmodule

`default_nettype wire

### design/gpb_color_pack.sv
// ---------------------------------------------------------------------------
// gpb_color_pack
// Packs an ARGB8888 color into the selected pixel format; each channel keeps
// the top bits of its source byte.
// ---------------------------------------------------------------------------
`default_nettype none

module gpb_color_pack
  import gpb_pkg::*;
(
  input  pixel_format_t             pixel_format,
  input  wire logic [COLOR_W-1:0]   text_color,
  output logic      [COLOR_W-1:0]   pixel_data,
  output logic                      write_wide
);

  logic [7:0] a;
  logic [7:0] g;
  logic [7:0] c0;
  logic [7:0] c2;
  logic       has_alpha;
  logic       swap_rb;
  depth_t     depth;

  // Split the color and pick the channel order
  always_comb begin
    a         = text_color[31:24];
    g         = text_color[15:8];
    has_alpha = pixel_format[3];
    swap_rb   = pixel_format[2];
    depth     = depth_t'(pixel_format[1:0]);
    c0        = swap_rb ? text_color[7:0]   : text_color[23:16];
    c2        = swap_rb ? text_color[23:16] : text_color[7:0];
  end

  // Assemble the packed word
  always_comb begin
    pixel_data = '0;
    write_wide = 1'b0;
    case (depth)
      DEPTH_444_1555: begin
        if (has_alpha) begin
          pixel_data[15:0] = {a[7], c0[7:3], g[7:3], c2[7:3]};
        end else begin
          pixel_data[15:0] = {4'h0, c0[7:4], g[7:4], c2[7:4]};
        end
      end
      DEPTH_555_4444: begin
        if (has_alpha) begin
          pixel_data[15:0] = {a[7:4], c0[7:4], g[7:4], c2[7:4]};
        end else begin
          pixel_data[15:0] = {1'b0, c0[7:3], g[7:3], c2[7:3]};
        end
      end
      DEPTH_565_8565: begin
        pixel_data[15:0] = {c0[7:3], g[7:2], c2[7:3]};
        if (has_alpha) begin
          pixel_data[23:16] = a;
          write_wide        = 1'b1;
        end
      end
      DEPTH_888_8888: begin
        pixel_data = {(has_alpha ? a : 8'h00), c0, g, c2};
        write_wide = 1'b1;
      end
      default: begin
        pixel_data = '0;
        write_wide = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

### design/gpb_blit_stage.sv
// ---------------------------------------------------------------------------
// gpb_blit_stage
// Two-register pixel pipe: an input register, then clip, pack and address
// logic feeding a result register. Clipped pixels are dropped in between.
// ---------------------------------------------------------------------------
`default_nettype none

module gpb_blit_stage
  import gpb_pkg::*;
#(
  parameter int MAX_DIM = DEFAULT_MAX_DIM
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  cfg_t                     cfg,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic signed [POS_W-1:0] dest_x,
  input  wire logic signed [POS_W-1:0] dest_y,
  input  wire logic [COV_W-1:0]    coverage,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [ADDR_W-1:0]        byte_address,
  output logic [COLOR_W-1:0]       pixel_data,
  output logic                     write_wide
);

  localparam logic [31:0] MAX_DIM_U = 32'(MAX_DIM);

  // Input register
  logic                    s1_valid;
  logic signed [POS_W-1:0] s1_x;
  logic signed [POS_W-1:0] s1_y;
  logic [COV_W-1:0]        s1_cov;

  // Datapath between the registers
  logic [DIM_W-1:0]      w_lim;
  logic [DIM_W-1:0]      h_lim;
  logic                  keep;
  logic [ADDR_W-1:0]     pix_index;
  logic [ADDR_W-1:0]     addr_next;
  logic [COLOR_W-1:0]    pix_next;
  logic                  wide_next;
  logic                  s1_advance;

  // Result register is free, or is being taken this cycle
  assign s1_advance = !out_valid || out_ready;
  assign in_ready   = !s1_valid || s1_advance;

  // Hold or load the input beat
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_x   <= dest_x;
      s1_y   <= dest_y;
      s1_cov <= coverage;
    end
  end

  // Saturate the frame size to the clip limit
  always_comb begin
    w_lim = ({20'd0, cfg.frame_width}  > MAX_DIM_U) ? DIM_W'(MAX_DIM) : cfg.frame_width;
    h_lim = ({20'd0, cfg.frame_height} > MAX_DIM_U) ? DIM_W'(MAX_DIM) : cfg.frame_height;
  end

  // Clip: drop empty coverage and anything off the frame
  always_comb begin
    keep = (s1_cov != '0) && !s1_x[POS_W-1] && !s1_y[POS_W-1]
        && (s1_x[DIM_W-1:0] < w_lim) && (s1_y[DIM_W-1:0] < h_lim);
  end

  gpb_color_pack u_pack (
    .pixel_format (cfg.pixel_format),
    .text_color   (cfg.text_color),
    .pixel_data   (pix_next),
    .write_wide   (wide_next)
  );

  // Pixel index x + width*y, then scale by bytes per pixel (wraps at 24 bits)
  always_comb begin
    pix_index = ({{(ADDR_W-DIM_W){1'b0}}, w_lim} * {{(ADDR_W-DIM_W){1'b0}}, s1_y[DIM_W-1:0]})
              + {{(ADDR_W-DIM_W){1'b0}}, s1_x[DIM_W-1:0]};
    addr_next = wide_next ? {pix_index[ADDR_W-3:0], 2'b00}
                          : {pix_index[ADDR_W-2:0], 1'b0};
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= s1_valid && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_valid && keep) begin
      byte_address <= addr_next;
      pixel_data   <= pix_next;
      write_wide   <= wide_next;
    end
  end

endmodule

`default_nettype wire

### bench/glyph_pixel_blit_format_pack_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// glyph_pixel_blit_format_pack_test
// Drives glyph pixels through the blit and format pack block and checks
// every frame buffer write against a local model of the clip test, the
// color pack and the address math. Runs directed cases for the clip edges
// and every pixel format, then randomized phases under several frame sizes,
// with random idling on both sides and one long receiver hold-off.
// ---------------------------------------------------------------------------

module glyph_pixel_blit_format_pack_test;
  import gpb_pkg::*;

  localparam int MAX_DIM       = DEFAULT_MAX_DIM;
  localparam int IDLE_PCT      = 38;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT   = 2000;
  localparam int PHASE_ITEMS   = 60;

  typedef struct packed {
    logic [ADDR_W-1:0]  byte_address;
    logic [COLOR_W-1:0] pixel_data;
    logic               write_wide;
  } pixel_write_t;

  logic                    clk;
  logic                    rst;
  logic                    cfg_write;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [COLOR_W-1:0]      cfg_data;
  logic                    in_valid;
  logic                    in_ready;
  logic signed [POS_W-1:0] dest_x;
  logic signed [POS_W-1:0] dest_y;
  logic [COV_W-1:0]        coverage;
  logic                    out_valid;
  logic                    out_ready;
  logic [ADDR_W-1:0]       byte_address;
  logic [COLOR_W-1:0]      pixel_data;
  logic                    write_wide;

  // Writes still owed by the block, oldest first
  pixel_write_t expected_writes[$];
  int           error_count = 0;
  logic         steady_flow = 1'b0;
  int           hold_cycles = 0;

  // Local copy of the register file
  logic [DIM_W-1:0]   frame_width_q  = RESET_WIDTH;
  logic [DIM_W-1:0]   frame_height_q = RESET_HEIGHT;
  pixel_format_t      pixel_format_q = FMT_ARGB1555;
  logic [COLOR_W-1:0] text_color_q   = RESET_COLOR;

  glyph_pixel_blit_format_pack #(
    .MAX_DIM(MAX_DIM)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .dest_x      (dest_x),
    .dest_y      (dest_y),
    .coverage    (coverage),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .byte_address(byte_address),
    .pixel_data  (pixel_data),
    .write_wide  (write_wide)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Pack the ARGB8888 color into the selected format
  function automatic logic [COLOR_W-1:0] pack_color(pixel_format_t fmt,
                                                    logic [COLOR_W-1:0] color,
                                                    output logic wide);
    logic [FMT_W-1:0] code;
    logic [7:0]       a, r, g, b, c0, c2;
    depth_t           depth;
    logic [COLOR_W-1:0] pix;
    code  = fmt;
    a     = color[31:24];
    r     = color[23:16];
    g     = color[15:8];
    b     = color[7:0];
    depth = depth_t'(code[1:0]);
    // BGR and ABGR families swap red and blue
    c0 = code[2] ? b : r;
    c2 = code[2] ? r : b;
    wide = 1'b0;
    if (!code[3]) begin
      case (depth)
        DEPTH_444_1555: pix = {20'd0, c0[7:4], g[7:4], c2[7:4]};
        DEPTH_555_4444: pix = {17'd0, c0[7:3], g[7:3], c2[7:3]};
        DEPTH_565_8565: pix = {16'd0, c0[7:3], g[7:2], c2[7:3]};
        default: begin
          pix  = {8'd0, c0, g, c2};
          wide = 1'b1;
        end
      endcase
    end else begin
      case (depth)
        DEPTH_444_1555: pix = {16'd0, a[7], c0[7:3], g[7:3], c2[7:3]};
        DEPTH_555_4444: pix = {16'd0, a[7:4], c0[7:4], g[7:4], c2[7:4]};
        DEPTH_565_8565: begin
          pix  = {8'd0, a, c0[7:3], g[7:2], c2[7:3]};
          wide = 1'b1;
        end
        default: begin
          pix  = {a, c0, g, c2};
          wide = 1'b1;
        end
      endcase
    end
    return pix;
  endfunction

  function automatic int frame_limit(logic [DIM_W-1:0] dim);
    return (int'(dim) > MAX_DIM) ? MAX_DIM : int'(dim);
  endfunction

  // Work out the write for one pixel; returns 0 when the pixel is dropped
  function automatic bit predict_write(logic signed [POS_W-1:0] x,
                                       logic signed [POS_W-1:0] y,
                                       logic [COV_W-1:0] cov,
                                       output pixel_write_t wr);
    int     w_lim, h_lim;
    longint addr;
    logic   wide;
    w_lim = frame_limit(frame_width_q);
    h_lim = frame_limit(frame_height_q);
    wr    = '0;
    if (cov == 0 || x < 0 || y < 0 || int'(x) >= w_lim || int'(y) >= h_lim)
      return 1'b0;
    wr.pixel_data = pack_color(pixel_format_q, text_color_q, wide);
    addr = (longint'(x) + longint'(w_lim) * longint'(y)) * (wide ? 4 : 2);
    wr.byte_address = addr[ADDR_W-1:0];
    wr.write_wide   = wide;
    return 1'b1;
  endfunction

  // Write one register, then drop the enable
  task automatic write_reg(cfg_index_t idx, logic [COLOR_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_FRAME_WIDTH:  frame_width_q  = value[DIM_W-1:0];
      CFG_FRAME_HEIGHT: frame_height_q = value[DIM_W-1:0];
      CFG_PIXEL_FORMAT: pixel_format_q = pixel_format_t'(value[FMT_W-1:0]);
      default:          text_color_q   = value;
    endcase
  endtask

  // Set up the whole register file; junk above the field width is ignored
  task automatic configure(int width, int height, pixel_format_t fmt,
                           logic [COLOR_W-1:0] color);
    write_reg(CFG_FRAME_WIDTH, ($urandom() & 32'hffff_f000) | width);
    write_reg(CFG_FRAME_HEIGHT, ($urandom() & 32'hffff_f000) | height);
    write_reg(CFG_PIXEL_FORMAT, ($urandom() & 32'hffff_fff0) | fmt);
    write_reg(CFG_TEXT_COLOR, color);
  endtask

  // Offer one pixel beat and hold it until accepted
  task automatic send_pixel(logic signed [POS_W-1:0] x, logic signed [POS_W-1:0] y,
                            logic [COV_W-1:0] cov);
    pixel_write_t wr;
    while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    dest_x   <= x;
    dest_y   <= y;
    coverage <= cov;
    do @(posedge clk); while (!in_ready);
    if (predict_write(x, y, cov, wr))
      expected_writes.push_back(wr);
  endtask

  // Mostly pixels inside the frame, some on its edges, the rest anywhere
  task automatic send_random_pixel();
    int w_lim, h_lim, kind;
    logic signed [POS_W-1:0] x, y;
    logic [COV_W-1:0] cov;
    w_lim = frame_limit(frame_width_q);
    h_lim = frame_limit(frame_height_q);
    kind  = $urandom_range(99);
    cov   = ($urandom_range(9) == 0) ? 8'd0 : COV_W'($urandom_range(255, 1));
    if (kind < 70 && w_lim > 0 && h_lim > 0) begin
      x = POS_W'($urandom_range(w_lim - 1));
      y = POS_W'($urandom_range(h_lim - 1));
    end else if (kind < 85) begin
      case ($urandom_range(3))
        0: x = POS_W'(w_lim - 1);
        1: x = POS_W'(w_lim);
        2: x = -1;
        default: x = 0;
      endcase
      case ($urandom_range(3))
        0: y = POS_W'(h_lim - 1);
        1: y = POS_W'(h_lim);
        2: y = -1;
        default: y = 0;
      endcase
    end else begin
      x   = POS_W'($urandom());
      y   = POS_W'($urandom());
      cov = COV_W'($urandom());
    end
    send_pixel(x, y, cov);
  endtask

  // Stop offering, wait for owed writes, then let the pipeline empty
  task automatic finish_phase();
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    @(posedge clk);
    while (expected_writes.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_writes.size() != 0) begin
      $error("%0d expected writes never arrived", expected_writes.size());
      error_count += expected_writes.size();
      expected_writes.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_reset_values();
    send_pixel(0, 0, 8'd1);
    send_pixel(2047, 2047, 8'd255);
    send_pixel(2048, 0, 8'h80);
    finish_phase();
  endtask

  task automatic test_clipping();
    configure(640, 480, FMT_RGB565, 32'hffff_ffff);
    send_pixel(-1, 0, 8'd255);
    send_pixel(0, -1, 8'd255);
    send_pixel(-4096, -4096, 8'd255);
    send_pixel(4095, 4095, 8'd255);
    send_pixel(639, 479, 8'd255);
    send_pixel(640, 0, 8'd1);
    send_pixel(0, 480, 8'd1);
    send_pixel(100, 100, 8'd0);
    finish_phase();
  endtask

  task automatic test_every_format();
    write_reg(CFG_TEXT_COLOR, 32'ha5c3_7e19);
    for (int f = 0; f < 16; f++) begin
      write_reg(CFG_PIXEL_FORMAT, f);
      send_pixel(3, 2, 8'h7f);
      finish_phase();
    end
  endtask

  task automatic test_random_phases();
    int width, height;
    logic [COLOR_W-1:0] color;
    for (int phase = 0; phase < 12; phase++) begin
      width  = $urandom_range(64, 1);
      height = $urandom_range(64, 1);
      color  = $urandom();
      case (phase)
        0: width = 0;
        1: begin
          width  = 4095;
          height = 4095;
          color  = 32'hffff_ffff;
        end
        2: begin
          width  = 1;
          height = 1;
          color  = 32'h0;
        end
        3: begin
          width  = 2048;
          height = 2048;
        end
        4: height = 0;
        default: begin
          if ($urandom_range(3) == 0) begin
            width  = $urandom_range(4095, 1);
            height = $urandom_range(4095, 1);
          end
        end
      endcase
      configure(width, height, pixel_format_t'($urandom_range(15)), color);
      // Run one phase with no idling on either side
      steady_flow = (phase == 5);
      repeat (PHASE_ITEMS) send_random_pixel();
      steady_flow = 1'b0;
      finish_phase();
    end
  endtask

  task automatic test_back_pressure();
    configure(64, 64, FMT_ARGB8888, $urandom());
    hold_cycles = 300;
    steady_flow = 1'b1;
    for (int i = 0; i < 40; i++)
      send_pixel(POS_W'($urandom_range(63)), POS_W'($urandom_range(63)),
                 COV_W'($urandom_range(255, 1)));
    steady_flow = 1'b0;
    finish_phase();
  endtask

  // Check each write beat against the oldest expectation, then pick ready
  initial begin
    pixel_write_t exp_wr;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (expected_writes.size() == 0) begin
          $error("unexpected write: byte_address %h pixel_data %h write_wide %b",
                 byte_address, pixel_data, write_wide);
          error_count++;
        end else begin
          exp_wr = expected_writes.pop_front();
          if (byte_address !== exp_wr.byte_address) begin
            $error("byte_address: expected %h, got %h", exp_wr.byte_address, byte_address);
            error_count++;
          end
          if (pixel_data !== exp_wr.pixel_data) begin
            $error("pixel_data: expected %h, got %h", exp_wr.pixel_data, pixel_data);
            error_count++;
          end
          if (write_wide !== exp_wr.write_wide) begin
            $error("write_wide: expected %b, got %b", exp_wr.write_wide, write_wide);
            error_count++;
          end
        end
      end
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else if (steady_flow) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    rst       = 1'b1;
    cfg_write = 1'b0;
    cfg_index = CFG_FRAME_WIDTH;
    cfg_data  = '0;
    in_valid  = 1'b0;
    dest_x    = '0;
    dest_y    = '0;
    coverage  = '0;
    out_ready = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_values();
    test_clipping();
    test_every_format();
    test_random_phases();
    test_back_pressure();
    if (error_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // Give up if the run hangs
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

### sim.f
design/gpb_pkg.sv
design/gpb_cfg_regs.sv
design/gpb_color_pack.sv
design/gpb_blit_stage.sv
design/glyph_pixel_blit_format_pack.sv
bench/glyph_pixel_blit_format_pack_test.sv
